[rtl/zrpe_pkg.sv]
package zrpe_pkg;

  // Geometry
  localparam int MAX_SIDE      = 64;
  localparam int TABLE_ENTRIES = 16;
  localparam int PIX_CAP       = MAX_SIDE * MAX_SIDE;
  localparam int PIX_CAP_CLIP  = (PIX_CAP > 8191) ? 8191 : PIX_CAP;
  localparam logic [12:0] PIX_CAP13 = 13'(PIX_CAP_CLIP);

  // Configuration register indexes
  localparam logic [1:0] REG_COMPACT    = 2'd0;
  localparam logic [1:0] REG_PIXELS     = 2'd1;
  localparam logic [1:0] REG_REMAP_LOW  = 2'd2;
  localparam logic [1:0] REG_REMAP_HIGH = 2'd3;

  localparam logic [12:0] PIXELS_RESET = 13'd4096;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_SHORT     = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd2;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       first_byte;
    logic       last_byte;
  } code_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic [7:0] run_length;
    logic       shape_done;
    logic [1:0] status;
  } run_t;

  // What the front decided a byte means
  typedef enum logic [2:0] {
    KIND_LITERAL,
    KIND_RUN,
    KIND_MARKER,
    KIND_NULL_COUNT,
    KIND_BAD_INDEX
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;   // pixel for literals, count for runs
    logic       first;
    logic       last;
  } cmd_t;

endpackage

[rtl/zrpe_front.sv]
module zrpe_front
  import zrpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  code_t       code,
  input  logic        compact_mode,
  input  logic [63:0] remap_low,
  input  logic [63:0] remap_high,
  output cmd_t        cmd
);

  logic       awaiting;
  logic       awaiting_eff;
  logic       awaiting_next;
  logic [63:0] word;
  logic [7:0] mapped;

  assign awaiting_eff = code.first_byte ? 1'b0 : awaiting;

  // Colour table pick: bit 3 picks the word, bits 2:0 the byte
  assign word   = code.stream_byte[3] ? remap_high : remap_low;
  assign mapped = word[{code.stream_byte[2:0], 3'b000} +: 8];

  always_comb begin
    cmd.first = code.first_byte;
    cmd.last  = code.last_byte;
    cmd.value = code.stream_byte;
    awaiting_next = 1'b0;
    if (awaiting_eff) begin
      cmd.kind = (code.stream_byte == 8'd0) ? KIND_NULL_COUNT : KIND_RUN;
    end else if (code.stream_byte == 8'd0) begin
      cmd.kind      = KIND_MARKER;
      awaiting_next = 1'b1;
    end else if (compact_mode) begin
      if (code.stream_byte[7:4] != 4'd0) begin
        cmd.kind = KIND_BAD_INDEX;
      end else begin
        cmd.kind  = KIND_LITERAL;
        cmd.value = mapped;
      end
    end else begin
      cmd.kind = KIND_LITERAL;
    end
  end

  // Once a shape has finished this flag may drift; the next first byte clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting <= 1'b0;
    end else if (accept) begin
      awaiting <= awaiting_next;
    end
  end

endmodule

[rtl/zrpe_queue.sv]
module zrpe_queue
  import zrpe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic avail,
  input  logic pop,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/zrpe_back.sv]
module zrpe_back
  import zrpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        avail,
  input  cmd_t        cmd,
  output logic        pop,
  input  logic [12:0] pixel_count,
  output logic        run_valid,
  input  logic        run_stall,
  output run_t        run_data
);

  logic        finished;
  logic        finished_next;
  logic [12:0] emitted;
  logic [12:0] emitted_next;
  logic        finished_eff;
  logic [12:0] emitted_eff;
  logic [12:0] total;
  logic [7:0]  len;
  logic [13:0] sum;
  logic        has_res;
  run_t        res;

  assign pop = avail && (!run_valid || !run_stall);

  assign finished_eff = cmd.first ? 1'b0 : finished;
  assign emitted_eff  = cmd.first ? 13'd0 : emitted;
  assign total        = (pixel_count > PIX_CAP13) ? PIX_CAP13 : pixel_count;
  assign len          = (cmd.kind == KIND_LITERAL) ? 8'd1 : cmd.value;
  assign sum          = {1'b0, emitted_eff} + {6'd0, len};

  always_comb begin
    has_res          = 1'b0;
    res.pixel_value  = 8'd0;
    res.run_length   = 8'd0;
    res.shape_done   = 1'b1;
    res.status       = STAT_OK;
    emitted_next     = emitted_eff;
    if (!finished_eff) begin
      unique case (cmd.kind)
        KIND_MARKER, KIND_NULL_COUNT: begin
          if (cmd.last) begin
            has_res    = 1'b1;
            res.status = STAT_SHORT;
          end
        end
        KIND_BAD_INDEX: begin
          has_res    = 1'b1;
          res.status = STAT_BAD_INDEX;
        end
        KIND_LITERAL, KIND_RUN: begin
          has_res = 1'b1;
          if (sum > {1'b0, total}) begin
            res.status = STAT_OVERFLOW;
          end else begin
            emitted_next = sum[12:0];
            if (sum == {1'b0, total}) begin
              res.pixel_value = (cmd.kind == KIND_LITERAL) ? cmd.value : 8'd0;
              res.run_length  = len;
            end else if (cmd.last) begin
              res.status = STAT_SHORT;
            end else begin
              res.pixel_value = (cmd.kind == KIND_LITERAL) ? cmd.value : 8'd0;
              res.run_length  = len;
              res.shape_done  = 1'b0;
            end
          end
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end
    finished_next = finished_eff | (has_res & res.shape_done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finished  <= 1'b1;
      emitted   <= 13'd0;
      run_valid <= 1'b0;
    end else if (pop) begin
      finished  <= finished_next;
      emitted   <= emitted_next;
      run_valid <= has_res;
    end else if (!run_stall) begin
      run_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      run_data <= res;
    end
  end

endmodule

[rtl/zero_run_pixel_expander.sv]
// Path: an accepted request goes through the command queue into the output register.
// Throughput: one coded byte per cycle while run_stall is low, set by the back end's
//   combinational add/compare on the pixel counter; the two-entry command queue lets
//   the front take up to two more requests while one finished run waits on run_stall.
// Reset (rst, synchronous, active high): config back to defaults (pixel_count 4096,
//   table zero, compact off), queue empty, shape marked finished until a first byte.
module zero_run_pixel_expander
  import zrpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // coded byte requests
  input  logic        code_valid,
  output logic        code_stall,
  input  code_t       code_data,
  // run results
  output logic        run_valid,
  input  logic        run_stall,
  output run_t        run_data,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic        compact_mode;
  logic [12:0] pixel_count;
  logic [63:0] remap_low;
  logic [63:0] remap_high;

  logic code_accept;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_avail;
  logic q_pop;

  // Register file: always writable; software must write it only while idle (unchecked).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      compact_mode <= 1'b0;
      pixel_count  <= PIXELS_RESET;
      remap_low    <= 64'd0;
      remap_high   <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COMPACT:    compact_mode <= cfg_data[0];
        REG_PIXELS:     pixel_count  <= cfg_data[12:0];
        REG_REMAP_LOW:  remap_low    <= cfg_data;
        REG_REMAP_HIGH: remap_high   <= cfg_data;
        default:        compact_mode <= compact_mode;
      endcase
    end
  end

  // Front takes a request whenever the queue has room.
  assign code_stall  = q_full;
  assign code_accept = code_valid && !code_stall;

  // Front: tracks the zero marker and maps literals through the colour table in compact mode.
  zrpe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (code_accept),
    .code         (code_data),
    .compact_mode (compact_mode),
    .remap_low    (remap_low),
    .remap_high   (remap_high),
    .cmd          (front_cmd)
  );

  zrpe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (code_accept),
    .push_cmd (front_cmd),
    .full     (q_full),
    .avail    (q_avail),
    .pop      (q_pop),
    .head     (head_cmd)
  );

  // Back: pixel accounting, error checks and the output register.
  zrpe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .avail       (q_avail),
    .cmd         (head_cmd),
    .pop         (q_pop),
    .pixel_count (pixel_count),
    .run_valid   (run_valid),
    .run_stall   (run_stall),
    .run_data    (run_data)
  );

endmodule

[rtl/zrpe_checker.sv]
module zrpe_checker
  import zrpe_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  code_stall,
  input logic  run_valid,
  input logic  run_stall,
  input run_t  run_data
);

  // A stalled run stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    run_valid && run_stall |=> run_valid)
    else $error("run request dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    run_valid && run_stall |=> $stable(run_data))
    else $error("run payload changed while stalled");

  // Right after reset the queue is empty and nothing is in the output register.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !run_valid && !code_stall)
    else $error("output or stall not clear after reset");

  // Errors always close the shape and carry no pixels.
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    run_valid && run_data.status != STAT_OK |->
      run_data.shape_done && run_data.run_length == 8'd0 &&
      run_data.pixel_value == 8'd0)
    else $error("malformed error result");

endmodule

bind zero_run_pixel_expander zrpe_checker u_zrpe_checker (
  .clk        (clk),
  .rst        (rst),
  .code_stall (code_stall),
  .run_valid  (run_valid),
  .run_stall  (run_stall),
  .run_data   (run_data)
);

[tb/sv/zero_run_pixel_expander_checker.sv]
module zero_run_pixel_expander_checker
  import zrpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        code_valid,
  input  logic        code_stall,
  input  code_t       code_data,
  input  logic        run_valid,
  input  logic        run_stall,
  input  run_t        run_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          runs_outstanding,
  output int          bytes_consumed
);

  // register copies
  logic        compact;
  logic [12:0] pixel_total;
  logic [63:0] palette_lo;
  logic [63:0] palette_hi;

  // shape state
  logic [12:0] pixels_out;
  logic        want_count;
  logic        shape_closed;

  run_t runs_due[$];
  int   fails;
  int   used;

  task automatic note_run(input logic [7:0] pix, input logic [7:0] len,
                          input logic done, input logic [1:0] st);
    run_t r;
    r.pixel_value = pix;
    r.run_length  = len;
    r.shape_done  = done;
    r.status      = st;
    runs_due.push_back(r);
    if (done) shape_closed = 1'b1;
  endtask

  // Shrunk totals land here too: pixels_out above the limit always overflows.
  task automatic add_pixels(input logic [7:0] pix, input logic [7:0] len, input logic last);
    logic [12:0] limit;
    logic [13:0] reach;
    limit = (pixel_total > PIX_CAP13) ? PIX_CAP13 : pixel_total;
    reach = {1'b0, pixels_out} + len;
    if (reach > {1'b0, limit}) begin
      note_run(8'h00, 8'h00, 1'b1, STAT_OVERFLOW);
    end else begin
      pixels_out = reach[12:0];
      if (reach == {1'b0, limit}) note_run(pix, len, 1'b1, STAT_OK);
      else if (last) note_run(8'h00, 8'h00, 1'b1, STAT_SHORT);
      else note_run(pix, len, 1'b0, STAT_OK);
    end
  endtask

  task automatic expand_byte(input code_t c);
    logic [7:0]  pix;
    logic [63:0] word;
    if (c.first_byte) begin
      pixels_out   = '0;
      want_count   = 1'b0;
      shape_closed = 1'b0;
    end
    if (!shape_closed) begin
      used++;
      if (want_count) begin
        want_count = 1'b0;
        if (c.stream_byte == 8'h00) begin
          if (c.last_byte) note_run(8'h00, 8'h00, 1'b1, STAT_SHORT);
        end else begin
          add_pixels(8'h00, c.stream_byte, c.last_byte);
        end
      end else if (c.stream_byte == 8'h00) begin
        want_count = 1'b1;
        if (c.last_byte) note_run(8'h00, 8'h00, 1'b1, STAT_SHORT);
      end else if (compact && c.stream_byte >= TABLE_ENTRIES) begin
        note_run(8'h00, 8'h00, 1'b1, STAT_BAD_INDEX);
      end else begin
        pix = c.stream_byte;
        if (compact) begin
          word = c.stream_byte[3] ? palette_hi : palette_lo;
          pix  = word[c.stream_byte[2:0]*8 +: 8];
        end
        add_pixels(pix, 8'd1, c.last_byte);
      end
    end
  endtask

  always @(posedge clk) begin
    run_t want;
    if (rst) begin
      compact      = 1'b0;
      pixel_total  = PIXELS_RESET;
      palette_lo   = '0;
      palette_hi   = '0;
      pixels_out   = '0;
      want_count   = 1'b0;
      shape_closed = 1'b1;
      runs_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COMPACT:    compact     = cfg_data[0];
          REG_PIXELS:     pixel_total = cfg_data[12:0];
          REG_REMAP_LOW:  palette_lo  = cfg_data;
          REG_REMAP_HIGH: palette_hi  = cfg_data;
          default: ;
        endcase
      end
      if (code_valid && !code_stall) expand_byte(code_data);
      if (run_valid && !run_stall) begin
        if (runs_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected run value=%0d len=%0d done=%0b status=%0d", $time,
                   run_data.pixel_value, run_data.run_length, run_data.shape_done,
                   run_data.status);
        end else begin
          want = runs_due.pop_front();
          if (run_data !== want) begin
            fails++;
            $display("%0t: run mismatch expected value=%0d len=%0d done=%0b status=%0d",
                     $time, want.pixel_value, want.run_length, want.shape_done, want.status);
            $display("%0t:              actual value=%0d len=%0d done=%0b status=%0d",
                     $time, run_data.pixel_value, run_data.run_length, run_data.shape_done,
                     run_data.status);
          end
        end
      end
    end
    mismatches       <= fails;
    runs_outstanding <= runs_due.size();
    bytes_consumed   <= used;
  end

endmodule

[tb/sv/zero_run_pixel_expander_tb.sv]
module zero_run_pixel_expander_tb;
  import zrpe_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;  // watchdog limit
  localparam int BYTE_TARGET = 2000;     // coded bytes the block actually consumes

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        code_valid = 1'b0;
  logic        code_stall;
  code_t       code_data = '0;
  logic        run_valid;
  logic        run_stall = 1'b0;
  run_t        run_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_COMPACT;
  logic [63:0] cfg_data = '0;

  int          mismatches;
  int          runs_outstanding;
  int          bytes_consumed;
  int          cycles = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;        // phase with no idling on either side

  // what was last written, used to shape well-formed streams
  logic        cur_compact = 1'b0;
  logic [12:0] cur_pixels = PIXELS_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  zero_run_pixel_expander DUT (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_data  (code_data),
    .run_valid  (run_valid),
    .run_stall  (run_stall),
    .run_data   (run_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  zero_run_pixel_expander_checker run_check (
    .clk              (clk),
    .rst              (rst),
    .code_valid       (code_valid),
    .code_stall       (code_stall),
    .code_data        (code_data),
    .run_valid        (run_valid),
    .run_stall        (run_stall),
    .run_data         (run_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .runs_outstanding (runs_outstanding),
    .bytes_consumed   (bytes_consumed)
  );

  // Run side: after every accepted run, draw a fresh random stall (possibly none),
  // starting right at the next cycle.
  always @(posedge clk) begin
    int pause;
    if (rst) begin
      stall_left <= 0;
      run_stall  <= 1'b0;
    end else if (run_valid && !run_stall) begin
      pause      = calm ? 0 : int'($urandom_range(0, 11));
      stall_left <= (pause > 0) ? pause - 1 : 0;
      run_stall  <= (pause > 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      run_stall  <= 1'b1;
    end else begin
      run_stall  <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL zero_run_pixel_expander");
      $finish;
    end
  end

  // One request on the code channel. A gap of 0 keeps valid high across requests.
  task automatic push_byte(input logic [7:0] b, input logic f, input logic l);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      code_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    code_valid <= 1'b1;
    code_data  <= '{stream_byte: b, first_byte: f, last_byte: l};
    do @(posedge clk); while (code_stall);
  endtask

  // Register write; bits above the field are random junk the block must drop.
  // Leaves cfg_valid high so back-to-back writes never toggle it within a step.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val, input int w);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ({$urandom, $urandom} << w) | val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_COMPACT) cur_compact = val[0];
    if (idx == REG_PIXELS) cur_pixels = val[12:0];
  endtask

  // Stop sending, wait until every predicted run is back, then let the
  // pipeline settle for bytes that produce nothing.
  task automatic wait_quiet();
    code_valid <= 1'b0;
    @(posedge clk);
    while (runs_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_table();
    case ($urandom_range(0, 3))
      0: pick_table = '0;
      1: pick_table = '1;
      default: pick_table = {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] some_literal();
    some_literal = cur_compact ? 8'($urandom_range(1, 15)) : 8'($urandom_range(1, 255));
  endfunction

  // Mostly well-formed shapes that fill exactly 'total' pixels. At most one in
  // four breaks early: marker or literal with last set, overflowing count,
  // out-of-table index in compact mode, or a shape simply left open.
  task automatic send_shape(input int total);
    int   left;
    int   len;
    int   step;
    int   cut;
    logic fst;
    logic lst;
    left = total;
    fst  = 1'b1;
    step = 0;
    cut  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : -1;
    if (total == 0) begin
      push_byte(some_literal(), 1'b1, 1'b0);  // nothing fits an empty shape
      return;
    end
    while (left > 0) begin
      if (step == cut) begin
        case ($urandom_range(0, 4))
          0: push_byte(8'h00, fst, 1'b1);
          1: push_byte(some_literal(), fst, 1'b1);
          2: begin
            push_byte(8'h00, fst, 1'b0);
            push_byte((left < 255) ? 8'($urandom_range(left + 1, 255)) : 8'hFF,
                      1'b0, 1'b0);
          end
          3: push_byte(8'($urandom_range(16, 255)), fst, 1'($urandom_range(0, 1)));
          default: ;  // abandoned; a later total change may shrink under it
        endcase
        return;
      end
      len  = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, (left > 255) ? 255 : left);
      left = left - len;
      lst  = (left == 0) ? 1'($urandom_range(0, 1)) : 1'b0;
      if (len == 1 && $urandom_range(0, 1) == 0) begin
        push_byte(some_literal(), fst, lst);
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          // empty zero run, consumes two bytes and yields nothing
          push_byte(8'h00, fst, 1'b0);
          push_byte(8'h00, 1'b0, 1'b0);
          fst = 1'b0;
        end
        push_byte(8'h00, fst, 1'b0);
        push_byte(8'(len), 1'b0, lst);
      end
      fst = 1'b0;
      step++;
    end
  endtask

  initial begin
    int total;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset configuration: plain literals, total 4096 ---
    push_byte(8'h55, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);   // longest zero run
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);   // zero count, no result
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);   // zero count on the last byte: early end
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'h12, 1'b0, 1'b0);   // shape over, ignored
    push_byte(8'h00, 1'b1, 1'b1);   // marker whose count never comes
    push_byte(8'h07, 1'b1, 1'b1);   // stream ends short
    wait_quiet();

    // --- directed, compact mode with a tiny shape ---
    write_reg(REG_COMPACT, 64'd1, 1);
    write_reg(REG_PIXELS, 64'd3, 13);
    write_reg(REG_REMAP_LOW, 64'hFEDC_BA98_7654_3210, 64);
    write_reg(REG_REMAP_HIGH, 64'h0011_2233_4455_66FF, 64);
    cfg_valid <= 1'b0;
    push_byte(8'h03, 1'b1, 1'b0);
    push_byte(8'h0F, 1'b0, 1'b0);   // top table entry
    push_byte(8'h10, 1'b0, 1'b0);   // first index past the table
    push_byte(8'h00, 1'b1, 1'b0);   // run too long for the shape
    push_byte(8'h05, 1'b0, 1'b0);
    push_byte(8'h02, 1'b1, 1'b0);   // exact fill, last on the closing byte
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h02, 1'b0, 1'b1);
    push_byte(8'h08, 1'b1, 1'b0);   // two of three pixels, then shrink total
    push_byte(8'h01, 1'b0, 1'b0);
    wait_quiet();
    write_reg(REG_PIXELS, 64'd1, 13);
    cfg_valid <= 1'b0;
    push_byte(8'h01, 1'b0, 1'b0);   // already past the new total
    wait_quiet();
    write_reg(REG_COMPACT, 64'd0, 1);
    write_reg(REG_PIXELS, 64'd0, 13);
    cfg_valid <= 1'b0;
    push_byte(8'h80, 1'b1, 1'b0);   // empty shape overflows at once

    // --- random phases; each starts idle so the registers may change ---
    while (bytes_consumed < BYTE_TARGET) begin
      wait_quiet();
      if ($urandom_range(0, 1) == 0) write_reg(REG_COMPACT, 64'($urandom_range(0, 1)), 1);
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 11))
          0: total = 0;
          1: total = 1;
          2: total = 4096;
          3: total = 8191;
          4: total = $urandom_range(4097, 8190);
          5: total = $urandom_range(100, 4095);
          default: total = $urandom_range(2, 48);
        endcase
        write_reg(REG_PIXELS, 64'(total), 13);
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_REMAP_LOW, pick_table(), 64);
      if ($urandom_range(0, 2) == 0) write_reg(REG_REMAP_HIGH, pick_table(), 64);
      cfg_valid <= 1'b0;
      calm  = ($urandom_range(0, 4) == 0);
      total = (cur_pixels > PIX_CAP13) ? PIX_CAP13 : cur_pixels;
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 9) < 8) begin
          send_shape(total);
        end else begin
          // noise: arbitrary bytes and flags
          repeat ($urandom_range(1, 8))
            push_byte(8'($urandom), 1'($urandom_range(0, 7) == 0),
                      1'($urandom_range(0, 7) == 0));
        end
      end
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && runs_outstanding == 0) begin
      $display("PASS zero_run_pixel_expander");
    end else begin
      $display("FAIL zero_run_pixel_expander");
    end
    $finish;
  end

endmodule
